FILE: rtl/core/qbrf_pkg.sv
// Shared types and constants of the quartic bisection root finder.
// No dependencies; all other files but the two channel interfaces refer to this package.
package qbrf_pkg;

    localparam int LIMB_W    = 32;
    localparam int PEND_W    = 34;
    localparam int CARRY_W   = 3;
    localparam int MAX_STEPS = 64;

    // Result status codes.
    localparam logic [1:0] ST_CONVERGED  = 2'd0;
    localparam logic [1:0] ST_BAD_BRACKET = 2'd1;
    localparam logic [1:0] ST_STEP_LIMIT = 2'd2;

    // Sign codes of a polynomial value.
    localparam logic [1:0] SG_ZERO = 2'd0;
    localparam logic [1:0] SG_POS  = 2'd1;
    localparam logic [1:0] SG_NEG  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_X4   = 3'd0;
    localparam logic [2:0] REG_COEF_X3   = 3'd1;
    localparam logic [2:0] REG_COEF_X2   = 3'd2;
    localparam logic [2:0] REG_COEF_X1   = 3'd3;
    localparam logic [2:0] REG_COEF_X0   = 3'd4;
    localparam logic [2:0] REG_TOLERANCE = 3'd5;
    localparam logic [2:0] REG_STEP_LIM  = 3'd6;

    // Operation of the accumulator cells: load, multiply or add.
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } t_cell_ctl;

endpackage

FILE: rtl/core/qbrf_in_if.sv
// Input channel of the root finder: a bracket of two Q16.16 end points.
// No dependencies.
interface qbrf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_guess;
    logic [31:0] right_guess;

    modport source (output valid, output left_guess, output right_guess, input ready);
    modport sink (input valid, input left_guess, input right_guess, output ready);
endinterface

FILE: rtl/core/qbrf_out_if.sv
// Output channel of the root finder: root, residual, status and step count.
// No dependencies.
interface qbrf_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] root;
    logic [31:0] residual;
    logic [1:0]  status;
    logic [6:0]  steps_used;

    modport source (output valid, output root, output residual, output status,
                    output steps_used, input ready);
    modport sink (input valid, input root, input residual, input status,
                  input steps_used, output ready);
endinterface

FILE: rtl/core/qbrf_cell.sv
// One 32-bit limb of the wide polynomial accumulator.
// Depends on qbrf_pkg for the limb widths and the cell control struct.
module qbrf_cell (
    input  logic                              i_clk,
    input  qbrf_pkg::t_cell_ctl               i_ctl,
    input  logic [qbrf_pkg::LIMB_W-1:0]       i_load_limb,
    input  logic [qbrf_pkg::LIMB_W-1:0]       i_m,
    input  logic [qbrf_pkg::PEND_W-1:0]       i_mul_add,
    input  logic [qbrf_pkg::CARRY_W-1:0]      i_carry,
    output logic [qbrf_pkg::LIMB_W-1:0]       o_limb,
    output logic [qbrf_pkg::LIMB_W-1:0]       o_hi,
    output logic [qbrf_pkg::CARRY_W-1:0]      o_carry
);

    logic [qbrf_pkg::LIMB_W-1:0]                   r_limb;
    logic [qbrf_pkg::PEND_W-1:0]                   r_pend;
    logic [2*qbrf_pkg::LIMB_W-1:0]                 prod;
    logic [qbrf_pkg::PEND_W:0]                     sum;

    assign prod = r_limb * i_m;
    assign sum  = {{(qbrf_pkg::PEND_W + 1 - qbrf_pkg::LIMB_W){1'b0}}, r_limb}
                + {1'b0, r_pend};

    // The product's upper half and the carry of the pending sum go to the next limb.
    assign o_limb  = r_limb;
    assign o_hi    = prod[2*qbrf_pkg::LIMB_W-1:qbrf_pkg::LIMB_W];
    assign o_carry = sum[qbrf_pkg::PEND_W:qbrf_pkg::LIMB_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_limb <= i_load_limb;
            r_pend <= '0;
        end else if (i_ctl.mul) begin
            r_limb <= prod[qbrf_pkg::LIMB_W-1:0];
            r_pend <= i_mul_add;
        end else if (i_ctl.add) begin
            r_limb <= sum[qbrf_pkg::LIMB_W-1:0];
            r_pend <= {{(qbrf_pkg::PEND_W - qbrf_pkg::CARRY_W){1'b0}}, i_carry};
        end
    end

endmodule

FILE: rtl/core/qbrf_chain.sv
// Row of accumulator cells and its Horner sequencer: evaluates the quartic
// exactly at one point. Depends on qbrf_pkg and qbrf_cell.
module qbrf_chain #(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [31:0]                            i_x,
    input  logic [4:0][COEF_WIDTH-1:0]             i_coef,
    output logic                                   o_done,
    output logic [((COEF_WIDTH+163)/32)*32-1:0]    o_acc
);

    localparam int LIMBS = (COEF_WIDTH + 163) / 32;
    localparam int NB    = LIMBS * qbrf_pkg::LIMB_W;
    localparam int CW    = $clog2(LIMBS);

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_ADD} t_cstate;

    t_cstate                              r_state;
    logic [2:0]                           r_k;
    logic [CW-1:0]                        r_cnt;
    logic [31:0]                          r_x;
    logic                                 r_done;
    qbrf_pkg::t_cell_ctl                  ctl;
    logic [NB-1:0]                        load_vec;
    logic [NB-1:0]                        add_vec;
    logic [NB-1:0]                        coef_ext;
    logic [LIMBS-1:0][31:0]               limb;
    logic [LIMBS-1:0][31:0]               hi;
    logic [LIMBS-1:0][2:0]                carry;
    logic [LIMBS-1:0][33:0]               mul_add;

    assign load_vec = {{(NB-COEF_WIDTH){i_coef[0][COEF_WIDTH-1]}}, i_coef[0]};

    always_comb begin
        coef_ext = '0;
        add_vec  = '0;
        case (r_k)
            3'd1: begin
                coef_ext = {{(NB-COEF_WIDTH){i_coef[1][COEF_WIDTH-1]}}, i_coef[1]};
                add_vec  = coef_ext << FRAC_BITS;
            end
            3'd2: begin
                coef_ext = {{(NB-COEF_WIDTH){i_coef[2][COEF_WIDTH-1]}}, i_coef[2]};
                add_vec  = coef_ext << (2*FRAC_BITS);
            end
            3'd3: begin
                coef_ext = {{(NB-COEF_WIDTH){i_coef[3][COEF_WIDTH-1]}}, i_coef[3]};
                add_vec  = coef_ext << (3*FRAC_BITS);
            end
            3'd4: begin
                coef_ext = {{(NB-COEF_WIDTH){i_coef[4][COEF_WIDTH-1]}}, i_coef[4]};
                add_vec  = coef_ext << (4*FRAC_BITS);
            end
            default: begin
                coef_ext = '0;
                add_vec  = '0;
            end
        endcase
    end

    always_comb begin
        ctl.load = i_start;
        ctl.mul  = (r_state == C_MUL);
        ctl.add  = (r_state == C_ADD);
    end

    // A negative multiplier is taken as its unsigned pattern; the excess
    // (accumulator shifted up one limb) is subtracted as inverted limbs plus one.
    genvar g;
    generate
        for (g = 0; g < LIMBS; g++) begin : g_limb
            if (g == 0) begin : g_first
                assign mul_add[g] = {2'b00, add_vec[31:0]};
                qbrf_cell u_limb (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_load_limb (load_vec[31:0]),
                    .i_m         (r_x),
                    .i_mul_add   (mul_add[g]),
                    .i_carry     (3'd0),
                    .o_limb      (limb[g]),
                    .o_hi        (hi[g]),
                    .o_carry     (carry[g])
                );
            end else begin : g_rest
                assign mul_add[g] = {2'b00, hi[g-1]}
                                  + {2'b00, (r_x[31] ? ~limb[g-1] : 32'd0)}
                                  + {2'b00, add_vec[g*32 +: 32]}
                                  + {33'd0, (r_x[31] && (g == 1))};
                qbrf_cell u_limb (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_load_limb (load_vec[g*32 +: 32]),
                    .i_m         (r_x),
                    .i_mul_add   (mul_add[g]),
                    .i_carry     (carry[g-1]),
                    .o_limb      (limb[g]),
                    .o_hi        (hi[g]),
                    .o_carry     (carry[g])
                );
            end
        end
    endgenerate

    assign o_acc  = limb;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_k     <= 3'd0;
            r_cnt   <= '0;
            r_x     <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_x;
                        r_k     <= 3'd1;
                        r_state <= C_MUL;
                    end
                end
                C_MUL: begin
                    r_cnt   <= '0;
                    r_state <= C_ADD;
                end
                C_ADD: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(LIMBS-1)) begin
                        if (r_k == 3'd4) begin
                            r_done  <= 1'b1;
                            r_state <= C_IDLE;
                        end else begin
                            r_k     <= r_k + 3'd1;
                            r_state <= C_MUL;
                        end
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/quartic_bisection_root_finder_top.sv
// Top level of the quartic bisection root finder.
// Depends on qbrf_pkg, qbrf_in_if, qbrf_out_if and qbrf_chain.
//
// Usage: a word on in_ch carries a bracket (left_guess, right_guess) in signed
// Q16.16. The block searches it by bisection for a root of the configured
// quartic and returns one word on out_ch: the last midpoint, the polynomial
// value there (saturated Q16.16), a status and the number of midpoints used.
// Coefficients, tolerance and step limit are written through the plain write
// port; the user writes them only while the block is idle, which the block
// itself does not enforce. They reset to zero, 66 and 40. Each evaluation of
// the polynomial in the accumulator row is a Horner step per coefficient after
// the leading one: a multiply, then add steps that ripple the carry through
// LIMBS = (COEF_WIDTH+163)/32 limbs of 32 bits (5 at the defaults). An item
// takes the two end evaluations plus one per midpoint, each midpoint also
// passing the next and decide states; a bad bracket ends after the end
// evaluations with root, residual and step count zero. One item is worked on
// at a time; in_ch is ready whenever no search runs. The result sits in an
// output register, so a new word is taken while a stalled receiver still holds
// the previous result; a finished search waits until that register is free.
// Reset is synchronous: it empties the output register and returns to idle.
module quartic_bisection_root_finder_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [2:0]                                i_cfg_idx,
    input  logic [((COEF_WIDTH > 31) ? COEF_WIDTH : 31)-1:0] i_cfg_data,
    qbrf_in_if.sink                                   in_ch,
    qbrf_out_if.source                                out_ch
);

    localparam int LIMBS = (COEF_WIDTH + 163) / 32;
    localparam int NB    = LIMBS * qbrf_pkg::LIMB_W;

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_DECIDE, S_NEXT, S_OUT} t_state;
    typedef enum logic [1:0] {P_LO, P_HI, P_MID} t_phase;

    t_state                       r_state;
    t_phase                       r_phase;
    logic [4:0][COEF_WIDTH-1:0]   r_coef;
    logic [30:0]                  r_tol;
    logic [6:0]                   r_step_lim;
    logic [31:0]                  r_lo;
    logic [31:0]                  r_hi;
    logic [31:0]                  r_mid;
    logic [1:0]                   r_s0;
    logic [6:0]                   r_cnt;
    logic [6:0]                   r_lim;
    logic [1:0]                   r_fsign;
    logic                         r_conv;
    logic [31:0]                  r_res;
    logic [31:0]                  r_fin_root;
    logic [31:0]                  r_fin_res;
    logic [1:0]                   r_fin_stat;
    logic [6:0]                   r_fin_steps;
    logic                         r_ov;
    logic [31:0]                  r_root;
    logic [31:0]                  r_resid;
    logic [1:0]                   r_status;
    logic [6:0]                   r_steps;

    logic                         in_acc;
    logic                         start;
    logic [31:0]                  x_start;
    logic [32:0]                  mid_sum;
    logic [31:0]                  mid_calc;
    logic                         done;
    logic [NB-1:0]                acc;
    logic [NB-1:0]                tol_vec;
    logic [NB-1:0]                acc_sh;
    logic [1:0]                   n_fsign;
    logic                         n_conv;
    logic [31:0]                  n_res;
    logic                         fits;
    logic                         bad;
    logic                         flip;
    logic                         out_free;
    logic [6:0]                   n_lim;

    assign in_ch.ready = (r_state == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !r_ov || out_ch.ready;

    // Floor of the mean of the two ends.
    assign mid_sum  = {r_lo[31], r_lo} + {r_hi[31], r_hi};
    assign mid_calc = mid_sum[32:1];

    always_comb begin
        case (r_state)
            S_IDLE:   x_start = in_ch.left_guess;
            S_DECIDE: x_start = r_hi;
            default:  x_start = mid_calc;
        endcase
    end

    assign start = in_acc || (r_state == S_NEXT)
                || ((r_state == S_DECIDE) && (r_phase == P_LO));

    qbrf_chain #(
        .FRAC_BITS  (FRAC_BITS),
        .COEF_WIDTH (COEF_WIDTH)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_x     (x_start),
        .i_coef  (r_coef),
        .o_done  (done),
        .o_acc   (acc)
    );

    // Sign, tolerance test and saturated residual of the finished value.
    assign tol_vec = {{(NB-31){1'b0}}, r_tol} << (3*FRAC_BITS);
    assign acc_sh  = $signed(acc) >>> (3*FRAC_BITS);
    assign fits    = (&acc_sh[NB-1:31]) || !(|acc_sh[NB-1:31]);

    always_comb begin
        if (acc[NB-1]) begin
            n_fsign = qbrf_pkg::SG_NEG;
        end else if (|acc) begin
            n_fsign = qbrf_pkg::SG_POS;
        end else begin
            n_fsign = qbrf_pkg::SG_ZERO;
        end
        n_conv = ($signed(acc) <= $signed(tol_vec)) && ($signed(acc) >= -$signed(tol_vec));
        if (fits) begin
            n_res = acc_sh[31:0];
        end else if (acc[NB-1]) begin
            n_res = 32'h8000_0000;
        end else begin
            n_res = 32'h7FFF_FFFF;
        end
    end

    assign bad  = (r_s0 != qbrf_pkg::SG_ZERO) && (r_fsign == r_s0);
    assign flip = (r_s0 != qbrf_pkg::SG_ZERO) && (r_fsign != qbrf_pkg::SG_ZERO)
                && (r_fsign != r_s0);

    always_comb begin
        if (r_step_lim == 7'd0) begin
            n_lim = 7'd1;
        end else if (r_step_lim > 7'(qbrf_pkg::MAX_STEPS)) begin
            n_lim = 7'(qbrf_pkg::MAX_STEPS);
        end else begin
            n_lim = r_step_lim;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef     <= '0;
            r_tol      <= 31'd66;
            r_step_lim <= 7'd40;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qbrf_pkg::REG_COEF_X4:   r_coef[0]  <= i_cfg_data[COEF_WIDTH-1:0];
                qbrf_pkg::REG_COEF_X3:   r_coef[1]  <= i_cfg_data[COEF_WIDTH-1:0];
                qbrf_pkg::REG_COEF_X2:   r_coef[2]  <= i_cfg_data[COEF_WIDTH-1:0];
                qbrf_pkg::REG_COEF_X1:   r_coef[3]  <= i_cfg_data[COEF_WIDTH-1:0];
                qbrf_pkg::REG_COEF_X0:   r_coef[4]  <= i_cfg_data[COEF_WIDTH-1:0];
                qbrf_pkg::REG_TOLERANCE: r_tol      <= i_cfg_data[30:0];
                qbrf_pkg::REG_STEP_LIM:  r_step_lim <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Search control and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_LO;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_lim   <= '0;
            r_s0    <= qbrf_pkg::SG_ZERO;
        end else begin
            if ((r_state == S_OUT) && out_free) begin
                r_ov <= 1'b1;
            end else if (r_ov && out_ch.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_lo    <= in_ch.left_guess;
                        r_hi    <= in_ch.right_guess;
                        r_cnt   <= '0;
                        r_lim   <= n_lim;
                        r_phase <= P_LO;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (done) begin
                        r_fsign <= n_fsign;
                        r_conv  <= n_conv;
                        r_res   <= n_res;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    case (r_phase)
                        P_LO: begin
                            r_s0    <= r_fsign;
                            r_phase <= P_HI;
                            r_state <= S_EVAL;
                        end
                        P_HI: begin
                            if (bad) begin
                                r_fin_root  <= '0;
                                r_fin_res   <= '0;
                                r_fin_stat  <= qbrf_pkg::ST_BAD_BRACKET;
                                r_fin_steps <= '0;
                                r_state     <= S_OUT;
                            end else begin
                                r_state <= S_NEXT;
                            end
                        end
                        default: begin
                            if (flip) begin
                                r_hi <= r_mid;
                            end else begin
                                r_lo <= r_mid;
                                r_s0 <= r_fsign;
                            end
                            if (r_conv || (r_cnt >= r_lim)) begin
                                r_fin_root  <= r_mid;
                                r_fin_res   <= r_res;
                                r_fin_stat  <= r_conv ? qbrf_pkg::ST_CONVERGED
                                                      : qbrf_pkg::ST_STEP_LIMIT;
                                r_fin_steps <= r_cnt;
                                r_state     <= S_OUT;
                            end else begin
                                r_state <= S_NEXT;
                            end
                        end
                    endcase
                end
                S_NEXT: begin
                    r_mid   <= mid_calc;
                    r_cnt   <= r_cnt + 7'd1;
                    r_phase <= P_MID;
                    r_state <= S_EVAL;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_root   <= r_fin_root;
                        r_resid  <= r_fin_res;
                        r_status <= r_fin_stat;
                        r_steps  <= r_fin_steps;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid      = r_ov;
    assign out_ch.root       = r_root;
    assign out_ch.residual   = r_resid;
    assign out_ch.status     = r_status;
    assign out_ch.steps_used = r_steps;

endmodule

FILE: dv/qbrf_bisect_checker.sv
// Checker of the quartic bisection root finder: mirrors the configuration,
// predicts each result word and compares it with what the block returns.
// Depends on qbrf_pkg, qbrf_in_if and qbrf_out_if.
module qbrf_bisect_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    qbrf_in_if          in_ch,
    qbrf_out_if         out_ch,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import qbrf_pkg::*;

    typedef struct packed {
        logic [31:0] root;
        logic [31:0] residual;
        logic [1:0]  status;
        logic [6:0]  steps_used;
    } t_answer;

    logic signed [15:0] coef_q [5];
    logic [30:0]        tol_q;
    logic [6:0]         limit_q;
    t_answer            answers_due [$];

    assign o_pending = answers_due.size();

    // Horner evaluation, exact, scaled by 2^64.
    function automatic logic signed [255:0] poly_value(logic signed [31:0] x);
        logic signed [255:0] acc;
        logic signed [255:0] term;
        acc = coef_q[0];
        for (int k = 1; k <= 4; k++) begin
            term = coef_q[k];
            acc  = acc * x + (term <<< (16 * k));
        end
        return acc;
    endfunction

    function automatic int sign_of(logic signed [255:0] v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic t_answer search_bracket(logic signed [31:0] left,
                                               logic signed [31:0] right);
        t_answer             ans;
        logic signed [31:0]  lo_end, hi_end, mid;
        logic signed [32:0]  sum;
        logic signed [255:0] f_mid, mag, bound, res;
        int                  s_lo, s_hi, s_mid, lim, count;
        logic                conv;
        lo_end = left;
        hi_end = right;
        s_lo   = sign_of(poly_value(lo_end));
        s_hi   = sign_of(poly_value(hi_end));
        ans    = '0;
        if (s_lo * s_hi > 0) begin
            ans.status = ST_BAD_BRACKET;
            return ans;
        end
        lim = limit_q;
        if (lim == 0) lim = 1;
        if (lim > MAX_STEPS) lim = MAX_STEPS;
        count = 0;
        bound = {225'd0, tol_q} <<< 48;
        do begin
            sum   = {lo_end[31], lo_end} + {hi_end[31], hi_end};
            mid   = sum[32:1];   // rounds toward minus infinity
            f_mid = poly_value(mid);
            count++;
            s_mid = sign_of(f_mid);
            if (s_lo * s_mid < 0) begin
                hi_end = mid;
            end else begin
                lo_end = mid;
                s_lo   = s_mid;
            end
            mag  = (f_mid < 0) ? -f_mid : f_mid;
            conv = (mag <= bound);
        end while (!conv && count < lim);
        res = f_mid >>> 48;
        if (res > 256'sh7FFF_FFFF)
            ans.residual = 32'h7FFF_FFFF;
        else if (res < -256'sh8000_0000)
            ans.residual = 32'h8000_0000;
        else
            ans.residual = res[31:0];
        ans.root       = mid;
        ans.status     = conv ? ST_CONVERGED : ST_STEP_LIMIT;
        ans.steps_used = count[6:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            foreach (coef_q[k]) coef_q[k] <= '0;
            tol_q        <= 31'd66;
            limit_q      <= 7'd40;
            answers_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_COEF_X4:   coef_q[0] <= i_cfg_data[15:0];
                    REG_COEF_X3:   coef_q[1] <= i_cfg_data[15:0];
                    REG_COEF_X2:   coef_q[2] <= i_cfg_data[15:0];
                    REG_COEF_X1:   coef_q[3] <= i_cfg_data[15:0];
                    REG_COEF_X0:   coef_q[4] <= i_cfg_data[15:0];
                    REG_TOLERANCE: tol_q     <= i_cfg_data;
                    REG_STEP_LIM:  limit_q   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                answers_due.push_back(search_bracket(in_ch.left_guess, in_ch.right_guess));
            if (out_ch.valid && out_ch.ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected word root=%h residual=%h status=%0d steps=%0d",
                             $time, out_ch.root, out_ch.residual, out_ch.status,
                             out_ch.steps_used);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (want != {out_ch.root, out_ch.residual, out_ch.status,
                                 out_ch.steps_used}) begin
                        $display("%0t: mismatch expected root=%h residual=%h status=%0d steps=%0d",
                                 $time, want.root, want.residual, want.status,
                                 want.steps_used);
                        $display("%0t:          actual   root=%h residual=%h status=%0d steps=%0d",
                                 $time, out_ch.root, out_ch.residual, out_ch.status,
                                 out_ch.steps_used);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

FILE: dv/testbench.sv
// Top of the root finder testbench: clock, reset, configuration phases and
// bracket stimulus, with random stalls on both channels and the verdict.
// Depends on qbrf_pkg, the two channel interfaces, the block and qbrf_bisect_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qbrf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [30:0] cfg_data;
    int          pending;
    int          fail_count;

    // Set while the run should have no random idling on either side.
    bit          steady;
    // Each increment asks the receiver for one long hold-off.
    int          hold_requests;

    qbrf_in_if  in_ch ();
    qbrf_out_if out_ch ();

    quartic_bisection_root_finder_top i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    qbrf_bisect_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // This bound allows several times the slowest search for every word of the run.
    initial begin
        #200_000_000;
        $display("quartic_bisection_root_finder_top test failed");
        $finish;
    end

    // Receiver: ready drops at random about eight percent of the time. On request it
    // holds off for a long stretch so that the block fills and stalls its input.
    initial begin
        int seen;
        seen = 0;
        out_ch.ready <= 1'b0;
        forever begin
            if (hold_requests != seen) begin
                seen = hold_requests;
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                out_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
                @(posedge i_clk);
            end
        end
    end

    // One register write per clock; the caller lowers the enable afterwards.
    task automatic write_reg(logic [2:0] idx, logic [30:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
    endtask

    // Loads a whole setting. Only called while no search runs and no word is due.
    task automatic load_setting(logic [15:0] c4, logic [15:0] c3, logic [15:0] c2,
                                logic [15:0] c1, logic [15:0] c0,
                                logic [30:0] tol, logic [6:0] lim);
        write_reg(REG_COEF_X4, {15'd0, c4});
        write_reg(REG_COEF_X3, {15'd0, c3});
        write_reg(REG_COEF_X2, {15'd0, c2});
        write_reg(REG_COEF_X1, {15'd0, c1});
        write_reg(REG_COEF_X0, {15'd0, c0});
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_STEP_LIM, {24'd0, lim});
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one bracket word and returns once it has been taken.
    task automatic offer_bracket(logic [31:0] left, logic [31:0] right);
        while (!steady && $urandom_range(0, 99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.left_guess  <= left;
        in_ch.right_guess <= right;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Waits until every word of the phase has come back.
    task automatic drain;
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // A bracket end: mostly a few units around zero, so that sign changes
    // are common, otherwise the whole signed range.
    function automatic logic [31:0] pick_end();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_coef(int mode);
        case (mode)
            0:       return 16'($urandom_range(0, 16) - 8);
            1:       return 16'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    function automatic logic [30:0] pick_tol();
        case ($urandom_range(0, 5))
            0:       return 31'd0;
            1:       return 31'd66;
            2:       return 31'h7FFF_FFFF;
            3:       return 31'($urandom);
            default: return 31'($urandom_range(0, 65535));
        endcase
    endfunction

    // Most phases use short step limits to keep the run short; a few use
    // zero, the full 64, or a value above 64.
    function automatic logic [6:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'($urandom_range(65, 127));
            default: return 7'($urandom_range(1, 24));
        endcase
    endfunction

    initial begin
        int mode;
        logic [31:0] left, right;
        steady        = 1'b0;
        hold_requests = 0;
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.left_guess  <= '0;
        in_ch.right_guess <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: the zero polynomial, so every end value is zero and
        // the first midpoint already converges.
        offer_bracket(32'h0001_0000, 32'h0003_0000);
        offer_bracket(32'h8000_0000, 32'h7FFF_FFFF);
        drain();

        // x^2 - 2: ordinary bracket, swapped bracket, bad bracket, a bracket on the
        // negative side, the field extremes and a degenerate bracket.
        load_setting(16'd0, 16'd0, 16'd1, 16'd0, -16'sd2, 31'd66, 7'd40);
        offer_bracket(32'h0000_0000, 32'h0002_0000);
        offer_bracket(32'h0002_0000, 32'h0000_0000);
        offer_bracket(32'h0003_0000, 32'h0004_0000);
        offer_bracket(32'hFFFE_0000, 32'hFFFF_0000);
        offer_bracket(32'h8000_0000, 32'h0000_0000);
        offer_bracket(32'h0000_0000, 32'h7FFF_FFFF);
        offer_bracket(32'hFFFF_FFFF, 32'h0000_0001);
        offer_bracket(32'h0001_0000, 32'h0001_0000);
        drain();

        // x - 1 has an exact zero at an end point.
        load_setting(16'd0, 16'd0, 16'd0, 16'd1, -16'sd1, 31'd0, 7'd0);
        offer_bracket(32'h0001_0000, 32'h0005_0000);
        offer_bracket(32'hFFFB_0000, 32'h0001_0000);
        offer_bracket(32'hFFFB_0000, 32'h0004_0000);
        drain();

        // Extreme coefficients; zero tolerance, limit over 64; then maximum tolerance, limit 64.
        load_setting(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 31'd0, 7'd127);
        offer_bracket(32'h8000_0000, 32'h7FFF_FFFF);
        offer_bracket(32'h0000_0000, 32'h0002_0000);
        drain();
        load_setting(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h0001, 31'h7FFF_FFFF,
                     7'd64);
        offer_bracket(32'h0000_0000, 32'h0000_8000);
        offer_bracket(32'hFFFF_8000, 32'h0001_0000);
        drain();

        // Random phases of about 110 brackets each under a fresh setting.
        for (int phase = 0; phase < 12; phase++) begin
            mode = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
            load_setting(pick_coef(mode), pick_coef(mode), pick_coef(mode),
                         pick_coef(mode), pick_coef(mode), pick_tol(), pick_limit());
            // One phase runs without any idling on either side.
            steady = (phase == 4);
            for (int n = 0; n < 110; n++) begin
                if (phase == 7 && n == 10) hold_requests++;
                left  = pick_end();
                right = pick_end();
                offer_bracket(left, right);
            end
            drain();
            steady = 1'b0;
        end

        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("quartic_bisection_root_finder_top test passed");
        else
            $display("quartic_bisection_root_finder_top test failed");
        $finish;
    end
endmodule
